// ===== hdl/obclm_pkg.sv =====
package obclm_pkg;
	localparam int TableDepthDefault = 64;

	typedef enum logic [1:0] {
		CODE_STATUS  = 2'd0,
		CODE_FULL    = 2'd1,
		CODE_UNKNOWN = 2'd2
	} code_t;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_LOCKED  = 2'd1,
		ST_CROSSED = 2'd2
	} book_t;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_MODIFY = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] order_id;
		logic        order_side;
		logic [31:0] order_price;
		logic [31:0] new_size;
		logic [30:0] event_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  report_code;
		logic [1:0]  book_state;
		logic [31:0] best_bid_price;
		logic [31:0] best_ask_price;
		logic [30:0] report_time;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic apply;
		logic eval;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic report;
	} dp_sts_t;
endpackage

// ===== hdl/obclm_ram.sv =====
module obclm_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/obclm_datapath.sv =====
module obclm_datapath #(
	parameter int TableDepth = obclm_pkg::TableDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  obclm_pkg::in_item_t  in_item,
	input  obclm_pkg::dp_cmd_t   cmd,
	output obclm_pkg::dp_sts_t   sts,
	output obclm_pkg::out_item_t result
);
	import obclm_pkg::*;

	localparam int AW = $clog2(TableDepth);

	in_item_t         item_q;
	logic [TableDepth-1:0] valid_q;
	logic [AW-1:0]    raddr_q;
	logic [AW-1:0]    addr_d1_q;
	logic             rd_live_q;
	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	logic             have_bid_q, have_ask_q;
	logic [31:0]      bid_q, ask_q;
	book_t            status_q;
	logic             report_q;
	out_item_t        result_q;

	logic [31:0] id_rd, price_rd;
	logic [0:0]  side_rd;
	logic        ram_we;
	logic [AW-1:0] waddr;
	logic [31:0] wid, wprice;
	logic        wside;
	logic        free_found;
	logic [AW-1:0] free_idx;
	logic        entry_ok;
	book_t       want;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TableDepth - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	assign ram_we = cmd.apply && ((item_q.kind == KIND_ADD) ? free_found :
		(hit_q && item_q.new_size != 32'd0));
	assign waddr  = (item_q.kind == KIND_ADD) ? free_idx : hit_idx_q;
	assign wid    = item_q.order_id;
	assign wprice = item_q.order_price;
	assign wside  = item_q.order_side;

	obclm_ram #(.Width(32), .Depth(TableDepth)) u_id (
		.clk, .we(ram_we && item_q.kind == KIND_ADD), .waddr, .wdata(wid),
		.raddr(raddr_q), .rdata(id_rd));
	obclm_ram #(.Width(32), .Depth(TableDepth)) u_price (
		.clk, .we(ram_we), .waddr, .wdata(wprice), .raddr(raddr_q), .rdata(price_rd));
	obclm_ram #(.Width(1), .Depth(TableDepth)) u_side (
		.clk, .we(ram_we && item_q.kind == KIND_ADD), .waddr, .wdata(wside),
		.raddr(raddr_q), .rdata(side_rd));

	assign entry_ok = rd_live_q && valid_q[addr_d1_q];

	always_comb begin
		if (!have_bid_q || !have_ask_q || ask_q > bid_q) begin
			want = ST_NORMAL;
		end else if (ask_q < bid_q) begin
			want = ST_CROSSED;
		end else begin
			want = ST_LOCKED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			raddr_q   <= '0;
			addr_d1_q <= '0;
			rd_live_q <= 1'b0;
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
			have_bid_q <= 1'b0;
			have_ask_q <= 1'b0;
			status_q  <= ST_NORMAL;
			report_q  <= 1'b0;
		end else begin
			rd_live_q <= cmd.scan_step;
			addr_d1_q <= raddr_q;
			if (cmd.scan_start) begin
				raddr_q    <= '0;
				hit_q      <= 1'b0;
				have_bid_q <= 1'b0;
				have_ask_q <= 1'b0;
			end else begin
				if (cmd.scan_step && raddr_q != AW'(TableDepth - 1)) begin
					raddr_q <= raddr_q + 1'b1;
				end
				if (entry_ok) begin
					if (!hit_q && id_rd == item_q.order_id) begin
						hit_q     <= 1'b1;
						hit_idx_q <= addr_d1_q;
					end
					if (side_rd[0]) begin
						if (!have_ask_q || price_rd < ask_q) ask_q <= price_rd;
						have_ask_q <= 1'b1;
					end else begin
						if (!have_bid_q || price_rd > bid_q) bid_q <= price_rd;
						have_bid_q <= 1'b1;
					end
				end
			end
			if (cmd.apply) begin
				if (item_q.kind == KIND_ADD && free_found) begin
					valid_q[free_idx] <= 1'b1;
				end else if (item_q.kind == KIND_MODIFY && hit_q &&
					item_q.new_size == 32'd0) begin
					valid_q[hit_idx_q] <= 1'b0;
				end
			end
			report_q <= 1'b0;
			if (cmd.apply) begin
				if (item_q.kind == KIND_ADD ? !free_found : !hit_q) begin
					report_q <= 1'b1;
				end
			end
			if (cmd.eval) begin
				if (want == ST_NORMAL && status_q != ST_NORMAL) begin
					status_q <= ST_NORMAL;
					report_q <= 1'b1;
				end else if (want != ST_NORMAL && status_q == ST_NORMAL) begin
					status_q <= want;
					report_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.apply) begin
			result_q.report_code    <= (item_q.kind == KIND_ADD) ? CODE_FULL : CODE_UNKNOWN;
			result_q.book_state     <= status_q;
			result_q.best_bid_price <= '0;
			result_q.best_ask_price <= '0;
			result_q.report_time    <= item_q.event_time;
		end
		if (cmd.eval) begin
			result_q.report_code    <= CODE_STATUS;
			result_q.book_state     <= want;
			result_q.best_bid_price <= (want == ST_NORMAL) ? 32'd0 : bid_q;
			result_q.best_ask_price <= (want == ST_NORMAL) ? 32'd0 : ask_q;
			result_q.report_time    <= item_q.event_time;
		end
	end

	assign sts.scan_last = !cmd.scan_step && !rd_live_q;
	assign sts.report    = report_q;
	assign result        = result_q;
endmodule

// ===== hdl/obclm_ctrl.sv =====
module obclm_ctrl #(
	parameter int TableDepth = obclm_pkg::TableDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output obclm_pkg::dp_cmd_t cmd,
	input  obclm_pkg::dp_sts_t sts
);
	import obclm_pkg::*;

	localparam int CW = $clog2(TableDepth + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_FIND, S_APPLY, S_CHECK, S_SCAN, S_EVAL, S_DECIDE, S_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.scan_start = cmd.load || (state_q == S_APPLY);
		cmd.scan_step  = (state_q == S_FIND || state_q == S_SCAN) &&
			cnt_q != CW'(TableDepth);
		cmd.apply      = (state_q == S_APPLY);
		cmd.eval       = (state_q == S_EVAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) state_q <= S_FIND;
				end
				S_FIND, S_SCAN: begin
					if (cnt_q != CW'(TableDepth)) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (sts.scan_last) begin
						cnt_q   <= '0;
						state_q <= (state_q == S_FIND) ? S_APPLY : S_EVAL;
					end
				end
				S_APPLY: state_q <= S_CHECK;
				S_CHECK: state_q <= sts.report ? S_OUT : S_SCAN;
				S_EVAL:  state_q <= S_DECIDE;
				S_DECIDE: state_q <= sts.report ? S_OUT : S_IDLE;
				S_OUT:   if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/order_book_cross_lock_monitor.sv =====
// Flow: a status result follows two scans of the order table, a rejected item's result
// follows one; each scan reads the table RAMs through registered read ports on one shared
// read address (id match first, then best prices).
// Throughput: one item at a time; in_ready is high only in idle, so a new item waits until
// the last one is done and any result that it gave has been taken.
// Reset: arst_n clears valid bits and book status to normal; table RAMs need none.
module order_book_cross_lock_monitor #(
	parameter int TABLE_DEPTH = obclm_pkg::TableDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  obclm_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output obclm_pkg::out_item_t out_data
);
	import obclm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	obclm_ctrl #(.TableDepth(TABLE_DEPTH)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts);

	obclm_datapath #(.TableDepth(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .sts, .result(out_data));

	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.report_code == CODE_STATUS |->
		out_data.book_state != ST_NORMAL ||
		(out_data.best_bid_price == 32'd0 && out_data.best_ask_price == 32'd0))
		else $error("normal report carries prices");
endmodule
